// ----- rtl/aabb_frustum_classify_core_defines.svh -----
// Assertion macros shared by the frustum classifier RTL.
`ifndef AABB_FRUSTUM_CLASSIFY_CORE_DEFINES_SVH
`define AABB_FRUSTUM_CLASSIFY_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during rst.
`define AFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and held off during rst.
`define AFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/afc_pkg.sv -----
// Types and constants of the frustum classifier.
package afc_pkg;

  localparam int NUM_PLANES = 6;

  // Verdict codes.
  localparam logic [1:0] VERDICT_OUTSIDE = 2'd0;
  localparam logic [1:0] VERDICT_PARTIAL = 2'd1;
  localparam logic [1:0] VERDICT_INSIDE  = 2'd2;

  // Register indexes on the configuration port.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd5;

  // Datapath widths: doubled centre, doubled extent, products and sums.
  localparam int COORD_W = 16;
  localparam int C2_W    = 18;
  localparam int E2_W    = 17;
  localparam int PROD_W  = 35;
  localparam int SUM_W   = 40;
  // 2*d in Q11.4 moved up to the Q.18 scale of the products.
  localparam int D_SHIFT = 15;

  typedef logic signed [C2_W-1:0] c2_t;
  typedef logic signed [E2_W-1:0] e2_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  // One plane register as written on the configuration port.
  typedef struct packed {
    logic signed [15:0] d;
    logic signed [15:0] nz;
    logic signed [15:0] ny;
    logic signed [15:0] nx;
  } plane_t;

  // Load enables for the two stages held inside each plane unit.
  typedef struct packed {
    logic s2_load;
    logic s3_load;
  } stage_ctl_t;

  // Result of one plane test.
  typedef struct packed {
    logic outside;
    logic partial;
  } plane_flags_t;

  // Sign-extends a product to the accumulator width.
  function automatic sum_t ext_prod(input prod_t v);
    return {{(SUM_W-PROD_W){v[PROD_W-1]}}, v};
  endfunction

endpackage

// ----- rtl/afc_plane.sv -----
// One plane test: product stage, sum stage and the final comparisons.
module afc_plane (
  input  logic                 clk,
  input  afc_pkg::stage_ctl_t  ctl,
  input  afc_pkg::plane_t      plane,
  input  afc_pkg::c2_t         c2 [3],
  input  afc_pkg::e2_t         e2 [3],
  output afc_pkg::plane_flags_t flags
);

  logic signed [15:0] nrm [3];
  logic signed [16:0] nrm_ext [3];
  logic [16:0] nrm_abs [3];

  afc_pkg::prod_t rprod [3];
  afc_pkg::prod_t dprod [3];
  logic signed [15:0] dist_d;

  afc_pkg::sum_t r2;
  afc_pkg::sum_t dist2;
  afc_pkg::sum_t d_term;

  // Normal magnitudes; the most negative normal still fits in 17 bits.
  always_comb begin
    nrm[0] = plane.nx;
    nrm[1] = plane.ny;
    nrm[2] = plane.nz;
    for (int i = 0; i < 3; i++) begin
      nrm_ext[i] = {nrm[i][15], nrm[i]};
      nrm_abs[i] = nrm_ext[i][16] ? 17'(-nrm_ext[i]) : nrm_ext[i];
    end
  end

  // Stage 2: radius and distance products, one multiplier each.
  always_ff @(posedge clk) begin
    if (ctl.s2_load) begin
      for (int i = 0; i < 3; i++) begin
        rprod[i] <= e2[i] * $signed({1'b0, nrm_abs[i]});
        dprod[i] <= nrm[i] * c2[i];
      end
      dist_d <= plane.d;
    end
  end

  // The plane offset, doubled and aligned to the product scale.
  assign d_term = {{(afc_pkg::SUM_W-16-afc_pkg::D_SHIFT){dist_d[15]}}, dist_d,
                   {afc_pkg::D_SHIFT{1'b0}}};

  // Stage 3: projected radius and signed centre distance.
  always_ff @(posedge clk) begin
    if (ctl.s3_load) begin
      r2 <= afc_pkg::ext_prod(rprod[0]) + afc_pkg::ext_prod(rprod[1])
            + afc_pkg::ext_prod(rprod[2]);
      dist2 <= afc_pkg::ext_prod(dprod[0]) + afc_pkg::ext_prod(dprod[1])
               + afc_pkg::ext_prod(dprod[2]) - d_term;
    end
  end

  // Both sums stay far below the accumulator range, so negation is exact.
  assign flags.outside = (-r2) > dist2;
  assign flags.partial = r2 >= dist2;

endmodule

// ----- rtl/aabb_frustum_classify_core.sv -----
// Top level of the box against frustum classifier.
//
//   channel   direction  handshake                      payload
//   input     in         in_valid / in_stall            box_min_*, box_max_*, origin_*
//   output    out        out_valid / out_stall          verdict
//   config    in         psel, penable, pwrite, pready  paddr, pwdata, prdata (64 bit)
//
// One item enters per cycle while in_stall is low; its verdict comes from the last stage.
// The four register stages are: centre and extent, products (one multiplier
// per term), plane sums, and the verdict register that drives the output.
// Reset is synchronous and clears the stage valid bits and the plane registers.
// Empty stages close up under an output stall, so in_stall rises only when all
// four stages hold items and the output is stalled.
module aabb_frustum_classify_core (
  input  logic               clk,
  input  logic               rst,
  // Input item channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] box_min_x,
  input  logic signed [15:0] box_min_y,
  input  logic signed [15:0] box_min_z,
  input  logic signed [15:0] box_max_x,
  input  logic signed [15:0] box_max_y,
  input  logic signed [15:0] box_max_z,
  input  logic signed [15:0] origin_x,
  input  logic signed [15:0] origin_y,
  input  logic signed [15:0] origin_z,
  // Result channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         verdict,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  afc_pkg::plane_t planes [afc_pkg::NUM_PLANES];
  logic [afc_pkg::CFG_IDX_W-1:0] reg_idx;

  logic signed [15:0] bmin [3];
  logic signed [15:0] bmax [3];
  logic signed [15:0] org [3];
  logic signed [16:0] wmin [3];
  logic signed [16:0] wmax [3];

  afc_pkg::c2_t c2_s1 [3];
  afc_pkg::e2_t e2_s1 [3];
  logic v1;
  logic v2;
  logic v3;

  logic ready1;
  logic ready2;
  logic ready3;
  logic ready4;

  afc_pkg::stage_ctl_t ctl;
  afc_pkg::plane_flags_t flags [afc_pkg::NUM_PLANES];
  logic any_outside;
  logic any_partial;
  logic [1:0] verdict_next;

  // Configuration registers: eight-byte spacing, writes past the list ignored.
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < afc_pkg::NUM_PLANES; i++) begin
        planes[i] <= '0;
      end
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx) inside
        afc_pkg::REG_PLANE_LEFT, afc_pkg::REG_PLANE_RIGHT, afc_pkg::REG_PLANE_FAR,
        afc_pkg::REG_PLANE_NEAR, afc_pkg::REG_PLANE_TOP,
        afc_pkg::REG_PLANE_BOTTOM: begin
          planes[reg_idx] <= pwdata;
        end
        default: begin
        end
      endcase
    end
  end

  // Read back of the plane registers.
  always_comb begin
    unique case (reg_idx) inside
      afc_pkg::REG_PLANE_LEFT, afc_pkg::REG_PLANE_RIGHT, afc_pkg::REG_PLANE_FAR,
      afc_pkg::REG_PLANE_NEAR, afc_pkg::REG_PLANE_TOP,
      afc_pkg::REG_PLANE_BOTTOM: begin
        prdata = planes[reg_idx];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  // A stage loads when it is empty or its contents move on this cycle.
  assign ready4   = !out_valid || !out_stall;
  assign ready3   = !v3 || ready4;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_stall = !ready1;

  assign ctl.s2_load = ready2;
  assign ctl.s3_load = ready3;

  // Stage 1: world corners, doubled centre and doubled extent per axis.
  always_comb begin
    bmin[0] = box_min_x;
    bmin[1] = box_min_y;
    bmin[2] = box_min_z;
    bmax[0] = box_max_x;
    bmax[1] = box_max_y;
    bmax[2] = box_max_z;
    org[0]  = origin_x;
    org[1]  = origin_y;
    org[2]  = origin_z;
    for (int i = 0; i < 3; i++) begin
      wmin[i] = {org[i][15], org[i]} + {bmin[i][15], bmin[i]};
      wmax[i] = {org[i][15], org[i]} + {bmax[i][15], bmax[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      for (int i = 0; i < 3; i++) begin
        c2_s1[i] <= {wmax[i][16], wmax[i]} + {wmin[i][16], wmin[i]};
        e2_s1[i] <= wmax[i] - wmin[i];
      end
    end
  end

  // Valid bits travel with the data through the four stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= in_valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
      if (ready4) begin
        out_valid <= v3;
      end
    end
  end

  // Stages 2 and 3: one test unit per plane.
  for (genvar p = 0; p < afc_pkg::NUM_PLANES; p++) begin : g_plane
    afc_plane u_plane (
      .clk   (clk),
      .ctl   (ctl),
      .plane (planes[p]),
      .c2    (c2_s1),
      .e2    (e2_s1),
      .flags (flags[p])
    );
  end

  // Stage 4: outside on any plane wins, then any partial plane.
  always_comb begin
    any_outside = 1'b0;
    any_partial = 1'b0;
    for (int p = 0; p < afc_pkg::NUM_PLANES; p++) begin
      any_outside = any_outside | flags[p].outside;
      any_partial = any_partial | flags[p].partial;
    end
    if (any_outside) begin
      verdict_next = afc_pkg::VERDICT_OUTSIDE;
    end else if (any_partial) begin
      verdict_next = afc_pkg::VERDICT_PARTIAL;
    end else begin
      verdict_next = afc_pkg::VERDICT_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (ready4) begin
      verdict <= verdict_next;
    end
  end

  // Checks on the stage control.
  `include "aabb_frustum_classify_core_defines.svh"

  `AFC_ASSERT_NOW(a_stall_only_when_full, in_stall, v1 && v2 && v3 && out_valid, "input stalled with an empty stage")
  `AFC_ASSERT_NEXT(a_no_repeat, out_valid && !out_stall && !v3, !out_valid, "result delivered twice")
  `AFC_ASSERT_NEXT(a_no_drop, v3 && out_valid && out_stall, v3 && out_valid, "item lost under an output stall")

endmodule
